// ----- rtl/cau_pkg.sv -----
// Shared types, codes and helpers for the complex arithmetic unit.
package cau_pkg;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 64;
    localparam int QBITS     = 33;  // quotient and root bits, one per cell
    localparam int NUM_CELLS = QBITS;
    localparam int SQ_REM_W  = 36;
    localparam int SQ_X_W    = 2 * QBITS;
    localparam int DEF_FRAC_BITS = 16;

    typedef enum logic [2:0] {
        KIND_ADD  = 3'd0,
        KIND_SUB  = 3'd1,
        KIND_MUL  = 3'd2,
        KIND_DIV  = 3'd3,
        KIND_CONJ = 3'd4,
        KIND_MAG  = 3'd5
    } t_kind;

    // Record handed from cell to cell.
    typedef struct packed {
        logic [2:0]          kind;
        logic [DATA_W-1:0]   pre_re;
        logic [DATA_W-1:0]   pre_im;
        logic                pre_sat;
        logic                dz;
        logic                neg_re;
        logic                neg_im;
        logic                big_re;
        logic                big_im;
        logic [PROD_W-1:0]   den;
        logic [PROD_W-1:0]   rem_re;
        logic [PROD_W-1:0]   rem_im;
        logic [QBITS-1:0]    q_re;
        logic [QBITS-1:0]    q_im;
        logic [QBITS-1:0]    lo_re;
        logic [QBITS-1:0]    lo_im;
        logic [SQ_X_W-1:0]   x;
        logic [SQ_REM_W-1:0] sq_rem;
        logic [QBITS-1:0]    root;
    } t_cell;

    // Clip a wide signed value to 32 bits; MSB of the result is the clip flag.
    function automatic logic [DATA_W:0] clip32(input logic signed [PROD_W:0] v);
        logic [DATA_W:0] r;
        if (v > 65'sd2147483647) begin
            r = {1'b1, 32'h7fff_ffff};
        end else if (v < -65'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[DATA_W-1:0]};
        end
        return r;
    endfunction

endpackage

// ----- rtl/cau_front.sv -----
// Operand products, simple results and divider/root set-up (three stages).
module cau_front #(
    parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [2:0]          i_kind,
    input  logic [127:0]        i_data,
    output logic                o_valid,
    output cau_pkg::t_cell      o_d
);
    import cau_pkg::*;

    typedef struct packed {
        logic [2:0]               kind;
        logic signed [PROD_W-1:0] rr, ii, ri, ir, sr, si, br2, bi2;
        logic [DATA_W-1:0]        pre_re, pre_im;
        logic                     pre_sat, bzero;
    } t_s1;

    typedef struct packed {
        logic [2:0]        kind;
        logic [DATA_W-1:0] pre_re, pre_im;
        logic              pre_sat, dz, neg_re, neg_im;
        logic [PROD_W-1:0] mag_re, mag_im, den, s;
    } t_s2;

    logic signed [DATA_W-1:0] ar, ai, br, bi;
    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_cell r_s3, n_s3;
    logic r_v1, r_v2, r_v3;

    logic [DATA_W:0] c_re, c_im;
    logic [DATA_W:0] c_re_s2, c_im_s2;
    logic signed [PROD_W:0] num_re, num_im, mre, mim;
    logic [PROD_W+FRAC_BITS-1:0] nf_re, nf_im;

    assign ar = i_data[31:0];
    assign ai = i_data[63:32];
    assign br = i_data[95:64];
    assign bi = i_data[127:96];

    // stage 1: products and add / subtract / conjugate
    always_comb begin
        n_s1 = '0;
        n_s1.kind = i_kind;
        n_s1.rr  = ar * br;
        n_s1.ii  = ai * bi;
        n_s1.ri  = ar * bi;
        n_s1.ir  = ai * br;
        n_s1.sr  = ar * ar;
        n_s1.si  = ai * ai;
        n_s1.br2 = br * br;
        n_s1.bi2 = bi * bi;
        n_s1.bzero = (br == '0) && (bi == '0);
        c_re = '0;
        c_im = '0;
        unique case (i_kind)
            KIND_ADD: begin
                c_re = clip32(65'(ar) + 65'(br));
                c_im = clip32(65'(ai) + 65'(bi));
            end
            KIND_SUB: begin
                c_re = clip32(65'(ar) - 65'(br));
                c_im = clip32(65'(ai) - 65'(bi));
            end
            KIND_CONJ: begin
                c_re = {1'b0, ar};
                c_im = clip32(-65'(ai));
            end
            default: ;
        endcase
        n_s1.pre_re  = c_re[DATA_W-1:0];
        n_s1.pre_im  = c_im[DATA_W-1:0];
        n_s1.pre_sat = c_re[DATA_W] | c_im[DATA_W];
    end

    // stage 2: product sums
    always_comb begin
        n_s2 = '0;
        n_s2.kind    = r_s1.kind;
        n_s2.pre_re  = r_s1.pre_re;
        n_s2.pre_im  = r_s1.pre_im;
        n_s2.pre_sat = r_s1.pre_sat;
        mre = 65'(r_s1.rr) - 65'(r_s1.ii);
        mim = 65'(r_s1.ri) + 65'(r_s1.ir);
        num_re = 65'(r_s1.rr) + 65'(r_s1.ii);
        num_im = 65'(r_s1.ir) - 65'(r_s1.ri);
        c_re_s2 = clip32(mre >>> FRAC_BITS);
        c_im_s2 = clip32(mim >>> FRAC_BITS);
        if (r_s1.kind == KIND_MUL) begin
            n_s2.pre_re  = c_re_s2[DATA_W-1:0];
            n_s2.pre_im  = c_im_s2[DATA_W-1:0];
            n_s2.pre_sat = c_re_s2[DATA_W] | c_im_s2[DATA_W];
        end
        n_s2.dz     = (r_s1.kind == KIND_DIV) && r_s1.bzero;
        n_s2.neg_re = num_re[PROD_W];
        n_s2.neg_im = num_im[PROD_W];
        n_s2.mag_re = num_re[PROD_W] ? PROD_W'(-num_re) : num_re[PROD_W-1:0];
        n_s2.mag_im = num_im[PROD_W] ? PROD_W'(-num_im) : num_im[PROD_W-1:0];
        n_s2.den    = r_s1.br2 + r_s1.bi2;
        n_s2.s      = r_s1.sr + r_s1.si;
    end

    // stage 3: dividend split, overflow test, root operand
    always_comb begin
        n_s3 = '0;
        n_s3.kind    = r_s2.kind;
        n_s3.pre_re  = r_s2.pre_re;
        n_s3.pre_im  = r_s2.pre_im;
        n_s3.pre_sat = r_s2.pre_sat;
        n_s3.dz      = r_s2.dz;
        n_s3.neg_re  = r_s2.neg_re;
        n_s3.neg_im  = r_s2.neg_im;
        n_s3.den     = r_s2.den;
        nf_re = {r_s2.mag_re, {FRAC_BITS{1'b0}}};
        nf_im = {r_s2.mag_im, {FRAC_BITS{1'b0}}};
        n_s3.lo_re  = nf_re[QBITS-1:0];
        n_s3.lo_im  = nf_im[QBITS-1:0];
        n_s3.rem_re = PROD_W'(nf_re >> QBITS);
        n_s3.rem_im = PROD_W'(nf_im >> QBITS);
        n_s3.big_re = PROD_W'(nf_re >> QBITS) >= r_s2.den;
        n_s3.big_im = PROD_W'(nf_im >> QBITS) >= r_s2.den;
        n_s3.x      = SQ_X_W'(r_s2.s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_v3;
    assign o_d     = r_s3;

endmodule

// ----- rtl/cau_cell.sv -----
// One cell: a restoring divide step for both parts and one square-root step.
module cau_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  cau_pkg::t_cell i_d,
    output logic           o_valid,
    output cau_pkg::t_cell o_d
);
    import cau_pkg::*;

    t_cell r_d, n_d;
    logic  r_valid;
    logic [PROD_W:0]   t_re, t_im;
    logic [SQ_REM_W-1:0] sr, st;
    logic ge_re, ge_im, ge_sq;

    always_comb begin
        n_d = i_d;
        t_re  = {i_d.rem_re, i_d.lo_re[QBITS-1]};
        t_im  = {i_d.rem_im, i_d.lo_im[QBITS-1]};
        ge_re = t_re >= {1'b0, i_d.den};
        ge_im = t_im >= {1'b0, i_d.den};
        n_d.rem_re = ge_re ? PROD_W'(t_re - {1'b0, i_d.den}) : t_re[PROD_W-1:0];
        n_d.rem_im = ge_im ? PROD_W'(t_im - {1'b0, i_d.den}) : t_im[PROD_W-1:0];
        n_d.q_re  = {i_d.q_re[QBITS-2:0], ge_re};
        n_d.q_im  = {i_d.q_im[QBITS-2:0], ge_im};
        n_d.lo_re = {i_d.lo_re[QBITS-2:0], 1'b0};
        n_d.lo_im = {i_d.lo_im[QBITS-2:0], 1'b0};
        // digit-by-digit root, two radicand bits a step
        sr = {i_d.sq_rem[SQ_REM_W-3:0], i_d.x[SQ_X_W-1 -: 2]};
        st = SQ_REM_W'({i_d.root, 2'b01});
        ge_sq = sr >= st;
        n_d.sq_rem = ge_sq ? sr - st : sr;
        n_d.root   = {i_d.root[QBITS-2:0], ge_sq};
        n_d.x      = {i_d.x[SQ_X_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

// ----- rtl/cau_back.sv -----
// Result selection, quotient and root clipping, output register.
module cau_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  cau_pkg::t_cell              i_d,
    output logic                        o_valid,
    output logic [cau_pkg::DATA_W-1:0]  o_re,
    output logic [cau_pkg::DATA_W-1:0]  o_im,
    output logic                        o_sat,
    output logic                        o_dz
);
    import cau_pkg::*;

    logic r_valid;
    logic [DATA_W-1:0] r_re, r_im, n_re, n_im;
    logic r_sat, r_dz, n_sat;
    logic [DATA_W:0] d_re, d_im;

    function automatic logic [DATA_W:0] div_fin(input logic neg, input logic big,
                                               input logic [QBITS-1:0] q);
        logic [DATA_W:0] r;
        if (neg) begin
            if (big || q[QBITS-1] || (q[DATA_W-1] && (q[DATA_W-2:0] != '0))) begin
                r = {1'b1, 32'h8000_0000};
            end else begin
                r = {1'b0, DATA_W'(-q)};
            end
        end else if (big || q[QBITS-1] || q[DATA_W-1]) begin
            r = {1'b1, 32'h7fff_ffff};
        end else begin
            r = {1'b0, q[DATA_W-1:0]};
        end
        return r;
    endfunction

    always_comb begin
        d_re  = div_fin(i_d.neg_re, i_d.big_re, i_d.q_re);
        d_im  = div_fin(i_d.neg_im, i_d.big_im, i_d.q_im);
        n_re  = i_d.pre_re;
        n_im  = i_d.pre_im;
        n_sat = i_d.pre_sat;
        if (i_d.kind == KIND_DIV && !i_d.dz) begin
            n_re  = d_re[DATA_W-1:0];
            n_im  = d_im[DATA_W-1:0];
            n_sat = d_re[DATA_W] | d_im[DATA_W];
        end else if (i_d.kind == KIND_MAG) begin
            n_im  = '0;
            n_sat = i_d.root[QBITS-1] | i_d.root[DATA_W-1];
            n_re  = n_sat ? 32'h7fff_ffff : i_d.root[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_re  <= n_re;
            r_im  <= n_im;
            r_sat <= n_sat;
            r_dz  <= i_d.dz;
        end
    end

    assign o_valid = r_valid;
    assign o_re    = r_re;
    assign o_im    = r_im;
    assign o_sat   = r_sat;
    assign o_dz    = r_dz;

endmodule

// ----- rtl/complex_arithmetic_unit_top.sv -----
// Complex arithmetic unit top level: front stages, cell chain, output stage.
//
// Usage notes:
// - Slave stream: one request per beat; tuser carries the operation code
//   (add, subtract, multiply, divide, conjugate, magnitude), tdata the four
//   Q16.16 operand parts a_re, a_im, b_re, b_im from the lowest bit up.
// - Master stream: one result per request, in order; tdata holds res_re,
//   res_im, tuser the saturated and div_zero flags.
// - Three front stages (products, sums, divider set-up), 33 cells and
//   the output register. Throughput is one request per cycle while the
//   output is not stalled; each cell yields one quotient bit for both
//   parts and one root bit, so the 33-bit quotient sets the chain length.
// - The whole pipeline moves together: it advances whenever the output
//   register is empty or being taken. While the receiver stalls a valid
//   result, every stage holds and s_axis_tready is low.
// - Reset (synchronous, active low) clears all valid bits; payload registers
//   are not reset. There is no other state.
// - Overflowing parts clip to the 32-bit range and raise saturated; a divide
//   by zero gives a zero result with div_zero set.
module complex_arithmetic_unit_top #(
    parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [127:0] i_s_axis_tdata,  // a_re, a_im, b_re, b_im
    input  logic [2:0]   i_s_axis_tuser,  // kind
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [63:0]  o_m_axis_tdata,  // res_re, res_im
    output logic [1:0]   o_m_axis_tuser   // saturated, div_zero
);
    import cau_pkg::*;

    logic  en;
    logic  f_valid;
    t_cell f_d;
    logic  c_valid [NUM_CELLS+1];
    t_cell c_d     [NUM_CELLS+1];
    logic [DATA_W-1:0] res_re, res_im;
    logic res_sat, res_dz;

    // advance when the output register is free or being emptied
    assign en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_kind  (i_s_axis_tuser),
        .i_data  (i_s_axis_tdata),
        .o_valid (f_valid),
        .o_d     (f_d)
    );

    assign c_valid[0] = f_valid;
    assign c_d[0]     = f_d;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        cau_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_valid[g]),
            .i_d     (c_d[g]),
            .o_valid (c_valid[g+1]),
            .o_d     (c_d[g+1])
        );
    end

    cau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c_valid[NUM_CELLS]),
        .i_d     (c_d[NUM_CELLS]),
        .o_valid (o_m_axis_tvalid),
        .o_re    (res_re),
        .o_im    (res_im),
        .o_sat   (res_sat),
        .o_dz    (res_dz)
    );

    assign o_m_axis_tdata = {res_im, res_re};
    assign o_m_axis_tuser = {res_dz, res_sat};

    // divide by zero never clips
    a_dz_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> !o_m_axis_tuser[0])
        else $error("div_zero with saturated");

    // divide by zero gives a zero result
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tdata == '0)
        else $error("div_zero with non-zero result");

    // nothing leaves straight after reset
    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule
